/* hw/rtl/etfp_pkg.sv */
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and helper functions for the escape-time fractal
// pixel block: channel words, controller/datapath links and color math.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int FRAC_BITS_DEF = 26;
    localparam int COUNT_BITS    = 12;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_R = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_I = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd3;

    localparam logic [COUNT_BITS-1:0] LIMIT_RST = COUNT_BITS'(256);

    localparam logic [31:0] RGBA_BLACK   = 32'h0000_00FF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  BYTE_MOD     = 8'd255;

    typedef struct packed {
        logic signed [31:0] point_re;
        logic signed [31:0] point_im;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iterations;
        logic [31:0]           pixel_rgba;
    } t_out_word;

    // Operand selection for the shared multiplier set
    typedef enum logic [1:0] {
        MUL_Z,      // zr*zr, zi*zi, zr*zi
        MUL_BULB,   // x*x,   ci*ci, dx*dx
        MUL_CARD    // q*(q+x)
    } t_mul_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BULB_SQ,
        S_BULB_Q,
        S_BULB_MUL,
        S_BULB_CMP,
        S_ITER_MUL,
        S_ITER_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     bulb_step;
        logic     bulb_eval;
        logic     iter_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bulb_hit;
        logic iter_stop;
    } t_dp_sts;

    // Value modulo 255: fold bytes (256 = 1 mod 255), then one correction.
    function automatic logic [7:0] mod255(input logic [23:0] v);
        logic [9:0] s1;
        logic [8:0] s2;
        s1 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]);
        s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
        if (s2 >= 9'(BYTE_MOD)) begin
            s2 = s2 - 9'(BYTE_MOD);
        end
        return s2[7:0];
    endfunction

endpackage

/* hw/rtl/escape_time_fractal_pixel.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Escape-time iteration of one complex point (Mandelbrot or Julia) to an
// iteration count and an RGBA color word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one point word:
//   re and im, signed 32-bit with FRAC_BITS fraction bits. Output channel
//   (o_out_valid / i_out_ready / o_out_word) returns one word per point:
//   the iteration count and the packed color.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) writes mode, Julia
//   constant or iteration limit, one per write; write only while idle.
// Timing:
//   One point at a time. In each iteration the shared set of three
//   multipliers fills its product registers, then z and the count update.
//   Julia mode goes straight to the loop; Mandelbrot mode first runs the
//   cardioid and bulb test, and a hit there skips the loop and reports
//   the iteration limit as the count.
//   The result waits in an output register; the block accepts the next
//   point as soon as that word is loaded, and only holds a finished result
//   in its sequencer while the output register is still full.
// Reset: synchronous, active low; clears the sequencer, the output valid,
//   and sets mode 0, Julia constant 0, iteration limit 256.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
    parameter int FRAC_BITS = etfp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  etfp_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output etfp_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [etfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [etfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import etfp_pkg::*;

    // Configuration registers
    logic                  r_mode;
    logic signed [31:0]    r_julia_re;
    logic signed [31:0]    r_julia_im;
    logic [COUNT_BITS-1:0] r_limit;

    // Output register
    logic      r_out_valid;
    t_out_word r_out_word;

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_word result;
    logic      out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_julia_re <= '0;
            r_julia_im <= '0;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:    r_mode     <= i_cfg_data[0];
                CFG_JULIA_R: r_julia_re <= i_cfg_data[31:0];
                CFG_JULIA_I: r_julia_im <= i_cfg_data[31:0];
                CFG_LIMIT:   r_limit    <= i_cfg_data[COUNT_BITS-1:0];
                default:     r_mode     <= r_mode;
            endcase
        end
    end

    // Hold the finished word in the sequencer while the output word waits
    assign out_busy = r_out_valid && !i_out_ready;

    etfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (r_mode),
        .i_out_busy (out_busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    etfp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_word  (i_in_word),
        .i_mode     (r_mode),
        .i_julia_re (r_julia_re),
        .i_julia_im (r_julia_im),
        .i_limit    (r_limit),
        .o_result   (result)
    );

    // Load a new word when the sequencer hands one over; drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* hw/rtl/etfp_ctrl.sv */
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer for one pixel: bulb pre-test in Mandelbrot mode, then the
// multiply/update loop, then hand-off to the output register.
// ----------------------------------------------------------------------------
module etfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic              i_out_busy,
    input  etfp_pkg::t_dp_sts i_sts,
    output etfp_pkg::t_dp_cmd o_cmd
);
    import etfp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_mode ? S_ITER_MUL : S_BULB_SQ;
                end
            end
            S_BULB_SQ:  n_state = S_BULB_Q;
            S_BULB_Q:   n_state = S_BULB_MUL;
            S_BULB_MUL: n_state = S_BULB_CMP;
            S_BULB_CMP: n_state = i_sts.bulb_hit ? S_DONE : S_ITER_MUL;
            S_ITER_MUL: n_state = S_ITER_ADD;
            S_ITER_ADD: n_state = i_sts.iter_stop ? S_DONE : S_ITER_MUL;
            S_DONE: begin
                if (!i_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.mul_sel   = MUL_Z;
        o_cmd.bulb_step = 1'b0;
        o_cmd.bulb_eval = 1'b0;
        o_cmd.iter_step = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_BULB_SQ:  o_cmd.mul_sel = MUL_BULB;
            S_BULB_Q:   o_cmd.bulb_step = 1'b1;
            S_BULB_MUL: o_cmd.mul_sel = MUL_CARD;
            S_BULB_CMP: o_cmd.bulb_eval = 1'b1;
            S_ITER_MUL: o_cmd.mul_sel = MUL_Z;
            S_ITER_ADD: o_cmd.iter_step = !i_sts.iter_stop;
            S_DONE:     o_cmd.out_load = !i_out_busy;
            default:    o_in_ready = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/etfp_dp.sv */
// ----------------------------------------------------------------------------
// etfp_dp
// Datapath: point and z registers, a shared set of three multipliers with
// registered products, bulb test, escape test, update and color.
// ----------------------------------------------------------------------------
module etfp_dp #(
    parameter int FRAC_BITS = etfp_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  etfp_pkg::t_dp_cmd                i_cmd,
    output etfp_pkg::t_dp_sts                o_sts,
    input  etfp_pkg::t_in_word               i_in_word,
    input  logic                             i_mode,
    input  logic signed [31:0]               i_julia_re,
    input  logic signed [31:0]               i_julia_im,
    input  logic [etfp_pkg::COUNT_BITS-1:0]  i_limit,
    output etfp_pkg::t_out_word              o_result
);
    import etfp_pkg::*;

    localparam int OPW = (FRAC_BITS + 7 > 33) ? FRAC_BITS + 7 : 33;
    localparam int PW  = 64;
    localparam int CW  = 24;

    localparam logic signed [31:0]    C_TWO     = 32'(2 ** (FRAC_BITS + 1));
    localparam logic signed [31:0]    C_NTWO    = -C_TWO;
    localparam logic signed [OPW-1:0] C_ONE     = OPW'(2 ** FRAC_BITS);
    localparam logic signed [OPW-1:0] C_QUARTER = OPW'(2 ** (FRAC_BITS - 2));
    localparam logic signed [PW-1:0]  C_BULB2   = 64'sd1 <<< (2 * FRAC_BITS - 4);
    localparam logic [PW-1:0]         C_BOUND   = 64'd4 << (2 * FRAC_BITS);

    logic signed [31:0]    r_zr, r_zi, r_cr, r_ci;
    logic [COUNT_BITS-1:0] r_n;
    logic signed [PW-1:0]  r_m0, r_m1, r_m2;
    logic signed [OPW-1:0] r_q, r_qx;
    logic signed [PW-1:0]  r_rhs;
    logic                  r_bulb2;
    logic                  r_inbox;

    logic signed [OPW-1:0]   cr_w, ci_w, zr_w, zi_w, x_w, dx_w;
    logic signed [OPW-1:0]   a0, b0, a1, b1, a2, b2;
    logic signed [2*OPW-1:0] p0, p1, p2;
    logic [PW-1:0]           mag;
    logic signed [PW-1:0]    re_full, im_full, q_full;
    logic                    inbox;
    logic                    hit;
    logic [CW-1:0]           n_ext;

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (!v[PW-1] && (|v[PW-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[PW-1] && !(&v[PW-2:31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign cr_w = OPW'(r_cr);
    assign ci_w = OPW'(r_ci);
    assign zr_w = OPW'(r_zr);
    assign zi_w = OPW'(r_zi);
    assign x_w  = cr_w - C_QUARTER;
    assign dx_w = cr_w + C_ONE;

    always_comb begin
        a0 = zr_w;
        b0 = zr_w;
        a1 = zi_w;
        b1 = zi_w;
        a2 = zr_w;
        b2 = zi_w;
        case (i_cmd.mul_sel)
            MUL_BULB: begin
                a0 = x_w;
                b0 = x_w;
                a1 = ci_w;
                b1 = ci_w;
                a2 = dx_w;
                b2 = dx_w;
            end
            MUL_CARD: begin
                a0 = r_q;
                b0 = r_qx;
            end
            default: begin
                a0 = zr_w;
            end
        endcase
    end

    assign p0 = a0 * b0;
    assign p1 = a1 * b1;
    assign p2 = a2 * b2;

    always_ff @(posedge i_clk) begin
        r_m0 <= p0[PW-1:0];
        r_m1 <= p1[PW-1:0];
        r_m2 <= p2[PW-1:0];
    end

    // Escape test and update from the registered products
    assign mag     = $unsigned(r_m0) + $unsigned(r_m1);
    assign re_full = ((r_m0 - r_m1) >>> FRAC_BITS) + PW'(r_cr);
    assign im_full = (r_m2 >>> (FRAC_BITS - 1)) + PW'(r_ci);

    // Bulb test pieces
    assign q_full = (r_m0 + r_m1) >>> FRAC_BITS;
    assign inbox  = (r_cr <= C_TWO) && (r_cr >= C_NTWO) &&
                    (r_ci <= C_TWO) && (r_ci >= C_NTWO);
    assign hit    = r_inbox && ((r_m0 < r_rhs) || r_bulb2);

    assign o_sts.bulb_hit  = hit;
    assign o_sts.iter_stop = (r_n >= i_limit) || (mag > C_BOUND);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= '0;
            if (i_mode) begin
                r_zr <= i_in_word.point_re;
                r_zi <= i_in_word.point_im;
                r_cr <= i_julia_re;
                r_ci <= i_julia_im;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= i_in_word.point_re;
                r_ci <= i_in_word.point_im;
            end
        end else if (i_cmd.iter_step) begin
            r_zr <= sat32(re_full);
            r_zi <= sat32(im_full);
            r_n  <= r_n + 1'b1;
        end else if (i_cmd.bulb_eval && hit) begin
            r_n <= i_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bulb_step) begin
            r_q     <= OPW'(q_full);
            r_qx    <= OPW'(q_full) + x_w;
            r_rhs   <= r_m1 >>> 2;
            r_bulb2 <= (r_m2 + r_m1) < C_BULB2;
            r_inbox <= inbox;
        end
    end

    assign n_ext = CW'(r_n);

    always_comb begin
        o_result.iterations = r_n;
        if (r_n == i_limit) begin
            o_result.pixel_rgba = RGBA_BLACK;
        end else begin
            o_result.pixel_rgba = {mod255(CW'(n_ext * 3)),
                                   mod255(CW'(n_ext * 6)),
                                   mod255(CW'(n_ext * 9)),
                                   ALPHA_OPAQUE};
        end
    end

`ifndef ASSERT_OFF
    a_step_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.iter_step |-> (r_n < i_limit))
        else $error("iteration step taken at or above the limit");

    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.iter_step && !i_cmd.load) |=> (r_n == $past(r_n) + 1'b1))
        else $error("iteration count did not advance by one");

    a_hit_gives_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bulb_eval && hit && !i_cmd.load && !i_cmd.iter_step)
            |=> (r_n == $past(i_limit)))
        else $error("bulb hit did not report the limit");
`endif

endmodule
